// ===== design/ask_pkg.sv =====
package ask_pkg;

  localparam int NumChannelsDef = 8;
  localparam int NumFilteredDef = 6;
  localparam int FracBitsDef    = 16;

  localparam int VarW   = 24;
  localparam int SampW  = 8;
  localparam int ChW    = 3;
  localparam int CmdW   = 2;
  localparam int KindW  = 2;

  localparam logic [VarW-1:0] VarMax = '1;

  // Register indexes on the configuration port
  localparam logic [0:0] RegQ = 1'b0;
  localparam logic [0:0] RegR = 1'b1;

  typedef enum logic [CmdW-1:0] {
    CMD_STORE  = 2'd0,
    CMD_FILTER = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [KindW-1:0] {
    KIND_STORED = 2'd0,
    KIND_EST    = 2'd1,
    KIND_RAW    = 2'd2
  } kind_t;

  // One queued job between the front and the back
  typedef struct packed {
    cmd_t             cmd;
    logic [SampW-1:0] sample;
    logic [ChW-1:0]   read_channel;
  } job_t;

  // One result beat
  typedef struct packed {
    kind_t            kind;
    logic [ChW-1:0]   channel;
    logic [SampW-1:0] value;
    logic [ChW-1:0]   next_channel;
    logic             last;
  } res_t;

endpackage

// ===== design/adc_scan_scalar_kalman.sv =====
// Channel  Direction  Beat contents
// in_      input      cmd, sample, read_channel
// out_     output     kind, channel, value, next_channel, last
// cfg_     APB write  process_noise (0x0), measurement_noise (0x4)
// A store or readback is written into the queue, then registered into its beat.
// A filter pass runs over six channels; each waits on the one-bit-a-cycle
// divider that forms the gain.
// Reset is synchronous and restores variances to 1.0 and samples to zero.
// A two-entry queue lets the input take beats while the back stalls on out_ready.
module adc_scan_scalar_kalman
  import ask_pkg::*;
#(
  parameter int NumChannels = NumChannelsDef,
  parameter int NumFiltered = NumFilteredDef,
  parameter int FracBits    = FracBitsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CmdW-1:0]  in_cmd,
  input  logic [SampW-1:0] in_sample,
  input  logic [ChW-1:0]   in_read_channel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KindW-1:0] out_kind,
  output logic [ChW-1:0]   out_channel,
  output logic [SampW-1:0] out_value,
  output logic [ChW-1:0]   out_next_channel,
  output logic             out_last,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [VarW-1:0] q_noise_r, r_noise_r;
  logic            q_valid, q_ready;
  job_t            q_job;
  res_t            res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {8'd0, (cfg_paddr[2] == RegR) ? r_noise_r : q_noise_r};

  // Noise registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_noise_r <= VarW'(65536);
      r_noise_r <= VarW'(65536);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == RegQ) q_noise_r <= cfg_pwdata[VarW-1:0];
      else                      r_noise_r <= cfg_pwdata[VarW-1:0];
    end
  end

  ask_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_sample(in_sample), .in_read_channel(in_read_channel),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  ask_back #(.NumChannels(NumChannels), .NumFiltered(NumFiltered),
             .FracBits(FracBits)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .q_noise(q_noise_r), .r_noise(r_noise_r), .res_valid(out_valid),
    .res_ready(out_ready), .res(res)
  );

  assign out_kind         = res.kind;
  assign out_channel      = res.channel;
  assign out_value        = res.value;
  assign out_next_channel = res.next_channel;
  assign out_last         = res.last;

endmodule

// ===== design/ask_front.sv =====
module ask_front
  import ask_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CmdW-1:0]  in_cmd,
  input  logic [SampW-1:0] in_sample,
  input  logic [ChW-1:0]   in_read_channel,
  output logic             q_valid,
  input  logic             q_ready,
  output job_t             q_job
);

  localparam int Depth = 2;

  job_t       mem_r [Depth];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  // Unused commands are dropped here and never reach the back
  assign in_ready = (cnt_r != 2'(Depth));
  assign push     = in_valid && in_ready && (cmd_t'(in_cmd) != CMD_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_job    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{cmd: cmd_t'(in_cmd), sample: in_sample, read_channel: in_read_channel};
    end
  end

endmodule

// ===== design/ask_div.sv =====
module ask_div
  import ask_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VarW-1:0]   num,
  input  logic [VarW:0]     den,
  output logic              done,
  output logic [FracBits:0] quo
);

  // Restoring division of num * 2^FracBits by den, one quotient bit a cycle
  localparam int QW = VarW + FracBits;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]  dvd_r, dvd_nxt;
  logic [VarW:0]  rem_r, rem_nxt;
  logic [VarW:0]  den_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt;
  logic [VarW+1:0] trial;

  assign trial = {rem_r, dvd_r[QW-1]} - {1'b0, den_r};
  assign done  = done_r;
  // K never exceeds one, so the top bits are zero
  assign quo   = (den_r == '0) ? '0 : dvd_r[FracBits:0];

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {num, {FracBits{1'b0}}};
      rem_nxt  = '0;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[VarW+1]) begin
        rem_nxt = trial[VarW:0];
        dvd_nxt = {dvd_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[VarW-1:0], dvd_r[QW-1]};
        dvd_nxt = {dvd_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

endmodule

// ===== design/ask_back.sv =====
module ask_back
  import ask_pkg::*;
#(
  parameter int NumChannels = NumChannelsDef,
  parameter int NumFiltered = NumFilteredDef,
  parameter int FracBits    = FracBitsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  job_t            q_job,
  input  logic [VarW-1:0] q_noise,
  input  logic [VarW-1:0] r_noise,
  output logic            res_valid,
  input  logic            res_ready,
  output res_t            res
);

  localparam int NumF  = (NumFiltered < NumChannels) ? NumFiltered : NumChannels;
  localparam int PtrW  = $clog2(NumChannels);
  localparam int FW    = (NumF > 1) ? $clog2(NumF) : 1;
  localparam int KW    = FracBits + 1;
  localparam int MW    = KW + VarW;
  localparam logic [VarW-1:0] OneSat =
    (FracBits >= VarW) ? VarMax : VarW'(64'(1) << FracBits);

  typedef enum logic [2:0] {
    S_IDLE, S_PRED, S_DIV, S_MUL, S_UPD, S_OUT
  } state_t;

  state_t              state_r;
  logic [PtrW-1:0]     ptr_r;
  logic [SampW-1:0]    raw_r [NumChannels];
  logic [SampW-1:0]    est_r [NumF];
  logic [VarW-1:0]     var_r [NumF];
  logic [FW-1:0]       k_r;
  logic [VarW-1:0]     pp_r;
  logic [KW-1:0]       gain_r;
  logic signed [KW+SampW+1:0] dprod_r;
  logic [KW-1:0]       pprod_r;
  logic                res_valid_r;
  res_t                res_r;

  logic                div_start, div_done;
  logic [KW-1:0]       div_q;
  logic [VarW:0]       pp_sum;
  logic [VarW-1:0]     pp_sat;
  logic [VarW:0]       den;
  logic signed [SampW+FracBits+KW+2:0] acc;
  logic [SampW+FracBits+KW+2:0] acc_sh;
  logic [SampW-1:0]    est_new;
  logic [PtrW-1:0]     ptr_inc;

  ask_div #(.FracBits(FracBits)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(pp_sat), .den(den),
    .done(div_done), .quo(div_q)
  );

  // Predicted variance, saturated, feeds the divider as it starts
  assign pp_sum    = {1'b0, var_r[k_r]} + {1'b0, q_noise};
  assign pp_sat    = pp_sum[VarW] ? VarMax : pp_sum[VarW-1:0];
  assign den       = {1'b0, pp_sat} + {1'b0, r_noise};
  assign div_start = (state_r == S_PRED);
  assign q_ready   = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign ptr_inc   = (ptr_r >= PtrW'(NumChannels - 1)) ? '0 : ptr_r + PtrW'(1);

  // New estimate: clamp the fixed-point sum at zero, drop the fraction, then saturate to 8 bits
  always_comb begin
    acc = $signed({1'b0, est_r[k_r], {FracBits{1'b0}}}) + dprod_r;
    acc_sh = (acc < 0) ? '0 : ($unsigned(acc) >> FracBits);
    est_new = (acc_sh > 255) ? 8'hFF : acc_sh[SampW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      k_r         <= '0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < NumChannels; i++) raw_r[i] <= '0;
      for (int i = 0; i < NumF; i++) begin
        est_r[i] <= '0;
        var_r[i] <= OneSat;
      end
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      case (state_r)
        // Take one job from the queue
        S_IDLE: begin
          if (q_valid && q_ready) begin
            case (q_job.cmd)
              CMD_STORE: begin
                raw_r[ptr_r] <= q_job.sample;
                ptr_r        <= ptr_inc;
                res_r        <= '{KIND_STORED, ChW'(ptr_r), q_job.sample,
                                  ChW'(ptr_inc), 1'b1};
                res_valid_r  <= 1'b1;
              end
              CMD_FILTER: begin
                k_r     <= '0;
                state_r <= S_PRED;
              end
              CMD_READ: begin
                res_r <= '{KIND_RAW, q_job.read_channel,
                           (32'(q_job.read_channel) < NumChannels) ?
                             raw_r[PtrW'(q_job.read_channel)] : '0,
                           ChW'(ptr_r), 1'b1};
                res_valid_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        // Predicted variance, saturated
        S_PRED: begin
          pp_r    <= pp_sat;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            gain_r  <= div_q;
            state_r <= S_MUL;
          end
        end
        // Two products from the gain
        S_MUL: begin
          dprod_r <= $signed({1'b0, gain_r}) *
                     ($signed({2'b0, raw_r[k_r]}) - $signed({2'b0, est_r[k_r]}));
          pprod_r <= KW'(1 << FracBits) - gain_r;
          state_r <= S_UPD;
        end
        S_UPD: begin
          est_r[k_r] <= est_new;
          var_r[k_r] <= VarW'((MW'(pprod_r) * MW'(pp_r)) >> FracBits);
          res_r      <= '{KIND_EST, ChW'(k_r), est_new, ChW'(ptr_r),
                          (k_r == FW'(NumF - 1))};
          res_valid_r <= 1'b1;
          state_r    <= S_OUT;
        end
        // Wait for the beat to leave before the next channel
        S_OUT: begin
          if (res_valid_r && res_ready) begin
            if (k_r == FW'(NumF - 1)) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + FW'(1);
              state_r <= S_PRED;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/ask_checker.sv =====
module ask_checker
  import ask_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KindW-1:0] out_kind,
  input logic [ChW-1:0]   out_channel,
  input logic             out_last
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_channel))
    else $error("result changed while stalled");

  // Stores and readbacks are always single beats
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_STORED || out_kind == KIND_RAW) |-> out_last)
    else $error("single-beat result without last");

  // Estimates on channel zero never close a pass of several channels
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EST && out_channel == 3'd0 |-> !out_last)
    else $error("filter pass ended early");

  // No invalid kind
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3)
    else $error("bad result kind");

endmodule

bind adc_scan_scalar_kalman ask_checker u_ask_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_kind(out_kind), .out_channel(out_channel), .out_last(out_last)
);
